// File: sv/two_class_age_ordered_fifo_assert.svh
// Assertion macros for the two-class age-ordered FIFO.
// Included by the RTL files that carry concurrent checks; clocked on i_clk.
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_ASSERT_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TCAOF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("two_class_age_ordered_fifo: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCAOF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("two_class_age_ordered_fifo: next-cycle check failed");

`else

`define TCAOF_ASSERT_NOW(label, ante, cons)
`define TCAOF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/tcaof_pkg.sv
// Types and codes shared by the two-class age-ordered FIFO.
// No dependencies.
`default_nettype none

package tcaof_pkg;

    localparam int TAG_W   = 16;
    localparam int ORDER_W = 32;
    localparam int ENTRY_W = ORDER_W + TAG_W;

    // Operation kinds.
    localparam logic [1:0] KIND_ENQ       = 2'd0;
    localparam logic [1:0] KIND_DEQ_ANY   = 2'd1;
    localparam logic [1:0] KIND_DEQ_NAMED = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Item classes.
    localparam logic CLASS_FIRST  = 1'b0;
    localparam logic CLASS_SECOND = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       item_class;
        logic [TAG_W-1:0] item_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   out_tag;
        logic               out_class;
        logic [ORDER_W-1:0] out_order;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/two_class_age_ordered_fifo.sv
// The result of an accepted item is loaded into the output register as the execute state
// ends; no new item is taken until the block is idle again. Both queue memories are read
// into registers at their head slots before the read-modify-write of pointers, counter
// and memory. A full output register stalls the execute state until the result is taken.
// Reset clears pointers, arrival counter and control; memories are not cleared.
`default_nettype none

module two_class_age_ordered_fifo
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int PW = $clog2(2 * QUEUE_DEPTH);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST  = PW'(2 * QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] PTR_DEPTH = PW'(QUEUE_DEPTH);
    localparam logic [PW:0]   USED_SPAN = (PW + 1)'(2 * QUEUE_DEPTH);
    localparam logic [PW:0]   USED_FULL = (PW + 1)'(QUEUE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= PTR_DEPTH) ? (p - PTR_DEPTH) : p;
        return s[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : (p + PW'(1));
    endfunction

    function automatic logic [PW:0] ptr_used(input logic [PW-1:0] h, input logic [PW-1:0] t);
        logic [PW:0] d;
        if (t >= h) begin
            d = {1'b0, t} - {1'b0, h};
        end else begin
            d = {1'b0, t} + USED_SPAN - {1'b0, h};
        end
        return d;
    endfunction

    logic               r_state, n_state;
    logic [PW-1:0]      r_head0, n_head0, r_tail0, n_tail0;
    logic [PW-1:0]      r_head1, n_head1, r_tail1, n_tail1;
    logic [ORDER_W-1:0] r_cnt, n_cnt;
    t_in_item           r_item;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [ENTRY_W-1:0] r_mem0 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_mem1 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd0, r_rd1;

    logic               w_in_fire, w_out_free, w_done;
    logic               w_empty0, w_empty1, w_full0, w_full1;
    logic [PW:0]        w_used0, w_used1;
    logic               w_cls, w_cls_ok;
    logic               w_we0, w_we1;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_pop0, w_pop1;
    logic [ORDER_W-1:0] w_age_diff;
    logic               w_pick;
    t_out_item          w_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_done     = (r_state == S_EXEC) && w_out_free;

    assign w_used0  = ptr_used(r_head0, r_tail0);
    assign w_used1  = ptr_used(r_head1, r_tail1);
    assign w_empty0 = (r_head0 == r_tail0);
    assign w_empty1 = (r_head1 == r_tail1);
    assign w_full0  = (w_used0 == USED_FULL);
    assign w_full1  = (w_used1 == USED_FULL);

    assign w_cls    = r_item.item_class[0];
    assign w_cls_ok = !r_item.item_class[1];
    assign w_wdata  = {r_cnt, r_item.item_tag};

    // The first front is older when the wrapped difference is negative; ties go second.
    assign w_age_diff = r_rd0[ENTRY_W-1 -: ORDER_W] - r_rd1[ENTRY_W-1 -: ORDER_W];
    assign w_pick     = w_empty0 ? CLASS_SECOND :
                        w_empty1 ? CLASS_FIRST  :
                        (w_age_diff[ORDER_W-1] ? CLASS_FIRST : CLASS_SECOND);

    // Decode the held item against the current pointers and the head read data.
    always_comb begin
        w_res  = '0;
        w_we0  = 1'b0;
        w_we1  = 1'b0;
        w_pop0 = 1'b0;
        w_pop1 = 1'b0;
        unique case (r_item.kind)
            KIND_ENQ: begin
                if (!w_cls_ok) begin
                    w_res.status = ST_INVALID;
                end else if ((w_cls == CLASS_SECOND) ? w_full1 : w_full0) begin
                    w_res.status    = ST_FULL;
                    w_res.out_class = w_cls;
                end else begin
                    w_res.status    = ST_OK;
                    w_res.out_class = w_cls;
                    w_res.out_order = r_cnt;
                    w_we0 = (w_cls == CLASS_FIRST);
                    w_we1 = (w_cls == CLASS_SECOND);
                end
            end
            KIND_DEQ_ANY: begin
                if (w_empty0 && w_empty1) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_res.status    = ST_OK;
                    w_res.out_class = w_pick;
                    w_pop0 = (w_pick == CLASS_FIRST);
                    w_pop1 = (w_pick == CLASS_SECOND);
                end
            end
            KIND_DEQ_NAMED: begin
                if (!w_cls_ok) begin
                    w_res.status = ST_INVALID;
                end else if ((w_cls == CLASS_SECOND) ? w_empty1 : w_empty0) begin
                    w_res.status    = ST_EMPTY;
                    w_res.out_class = w_cls;
                end else begin
                    w_res.status    = ST_OK;
                    w_res.out_class = w_cls;
                    w_pop0 = (w_cls == CLASS_FIRST);
                    w_pop1 = (w_cls == CLASS_SECOND);
                end
            end
            default: begin
                w_res.status = ST_INVALID;
            end
        endcase
        if (w_pop0) begin
            w_res.out_tag   = r_rd0[TAG_W-1:0];
            w_res.out_order = r_rd0[ENTRY_W-1 -: ORDER_W];
        end else if (w_pop1) begin
            w_res.out_tag   = r_rd1[TAG_W-1:0];
            w_res.out_order = r_rd1[ENTRY_W-1 -: ORDER_W];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head0     = r_head0;
        n_tail0     = r_tail0;
        n_head1     = r_head1;
        n_tail1     = r_tail1;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = w_res;
                    if (w_we0) begin
                        n_tail0 = ptr_next(r_tail0);
                    end
                    if (w_we1) begin
                        n_tail1 = ptr_next(r_tail1);
                    end
                    if (w_we0 || w_we1) begin
                        n_cnt = r_cnt + ORDER_W'(1);
                    end
                    if (w_pop0) begin
                        n_head0 = ptr_next(r_head0);
                    end
                    if (w_pop1) begin
                        n_head1 = ptr_next(r_head1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head0     <= '0;
            r_tail0     <= '0;
            r_head1     <= '0;
            r_tail1     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head0     <= n_head0;
            r_tail0     <= n_tail0;
            r_head1     <= n_head1;
            r_tail1     <= n_tail1;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= i_in_item;
        end
        r_out <= n_out;
    end

    // Both memories are read at their head slot every cycle. A write lands at the edge that
    // ends the execute state; the next item is accepted no earlier than the edge that ends
    // the following idle state, so the head data captured at that accept already has the write.
    always_ff @(posedge i_clk) begin
        if (w_done && w_we0) begin
            r_mem0[ptr_slot(r_tail0)] <= w_wdata;
        end
        r_rd0 <= r_mem0[ptr_slot(r_head0)];
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_we1) begin
            r_mem1[ptr_slot(r_tail1)] <= w_wdata;
        end
        r_rd1 <= r_mem1[ptr_slot(r_head1)];
    end

`include "two_class_age_ordered_fifo_assert.svh"

    `TCAOF_ASSERT_NOW(a_occupancy_bound, 1'b1, (w_used0 <= USED_FULL) && (w_used1 <= USED_FULL))
    `TCAOF_ASSERT_NOW(a_pop_nonempty, w_done && (w_pop0 || w_pop1), (w_pop0 ? !w_empty0 : !w_empty1))
    `TCAOF_ASSERT_NEXT(a_counter_only_on_enq, !(w_done && (w_we0 || w_we1)), $stable(r_cnt))
    `TCAOF_ASSERT_NEXT(a_accept_goes_exec, w_in_fire, r_state == S_EXEC)

endmodule

`default_nettype wire

// File: bench/tcaof_checker.sv
// Scoreboard for the two-class age-ordered FIFO: watches both channels, keeps its own
// copy of the two class queues and the arrival counter, and checks every result.
// Depends on tcaof_pkg.
module tcaof_checker
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Pointers carry one extra bit so that full and empty can be told apart.
    localparam int PTR_W = $clog2(QUEUE_DEPTH) + 1;

    logic [TAG_W-1:0]   slot_tag   [2][QUEUE_DEPTH];
    logic [ORDER_W-1:0] slot_order [2][QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_ptr   [2];
    logic [PTR_W-1:0]   tail_ptr   [2];
    logic [ORDER_W-1:0] arrival_count;
    t_out_item          results_due [$];

    function automatic logic class_empty(input logic cls);
        return head_ptr[cls] == tail_ptr[cls];
    endfunction

    function automatic t_out_item pop_class(input logic cls);
        t_out_item res;
        res = '0;
        res.out_class = cls;
        if (class_empty(cls)) begin
            res.status = ST_EMPTY;
        end else begin
            res.status    = ST_OK;
            res.out_tag   = slot_tag[cls][head_ptr[cls][PTR_W-2:0]];
            res.out_order = slot_order[cls][head_ptr[cls][PTR_W-2:0]];
            head_ptr[cls] = head_ptr[cls] + PTR_W'(1);
        end
        return res;
    endfunction

    // Applies one operation to the shelter model and returns the result it yields.
    function automatic t_out_item shelter_op(input t_in_item op);
        t_out_item          res;
        logic               cls;
        logic [PTR_W-1:0]   used;
        logic [ORDER_W-1:0] age_gap;
        res = '0;
        cls = op.item_class[0];
        case (op.kind)
            KIND_ENQ: begin
                // Classes two and three do not exist.
                if (op.item_class[1]) begin
                    res.status = ST_INVALID;
                end else begin
                    res.out_class = cls;
                    used = tail_ptr[cls] - head_ptr[cls];
                    if (used == PTR_W'(QUEUE_DEPTH)) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_tag[cls][tail_ptr[cls][PTR_W-2:0]]   = op.item_tag;
                        slot_order[cls][tail_ptr[cls][PTR_W-2:0]] = arrival_count;
                        tail_ptr[cls]  = tail_ptr[cls] + PTR_W'(1);
                        res.status     = ST_OK;
                        res.out_order  = arrival_count;
                        arrival_count  = arrival_count + ORDER_W'(1);
                    end
                end
            end
            KIND_DEQ_ANY: begin
                if (class_empty(CLASS_FIRST) && class_empty(CLASS_SECOND)) begin
                    res.status = ST_EMPTY;
                end else if (class_empty(CLASS_FIRST)) begin
                    res = pop_class(CLASS_SECOND);
                end else if (class_empty(CLASS_SECOND)) begin
                    res = pop_class(CLASS_FIRST);
                end else begin
                    // The first front is older only when the wrapped difference is
                    // negative; a tie goes to the second class.
                    age_gap = slot_order[CLASS_FIRST][head_ptr[CLASS_FIRST][PTR_W-2:0]]
                            - slot_order[CLASS_SECOND][head_ptr[CLASS_SECOND][PTR_W-2:0]];
                    res = pop_class(age_gap[ORDER_W-1] ? CLASS_FIRST : CLASS_SECOND);
                end
            end
            KIND_DEQ_NAMED: begin
                if (op.item_class[1]) begin
                    res.status = ST_INVALID;
                end else begin
                    res = pop_class(cls);
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [ORDER_W-1:0] want,
                                        input logic [ORDER_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                head_ptr[c] = '0;
                tail_ptr[c] = '0;
            end
            arrival_count = '0;
            results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(shelter_op(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transfer with none expected: status %0h tag %0h",
                             $time, i_out_item.status, i_out_item.out_tag);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", ORDER_W'(want.status),
                                ORDER_W'(i_out_item.status));
                    check_field("out_tag", ORDER_W'(want.out_tag),
                                ORDER_W'(i_out_item.out_tag));
                    check_field("out_class", ORDER_W'(want.out_class),
                                ORDER_W'(i_out_item.out_class));
                    check_field("out_order", want.out_order, i_out_item.out_order);
                end
            end
        end
        o_results_due = results_due.size();
    end

endmodule

// File: bench/two_class_age_ordered_fifo_tb.sv
// Top of the two-class age-ordered FIFO bench: clock, reset, stimulus and verdict.
// Instantiates the block and tcaof_checker; depends on tcaof_pkg.
module two_class_age_ordered_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcaof_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 250;

    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] CLS_FIRST  = {1'b0, CLASS_FIRST};
    localparam logic [1:0] CLS_SECOND = {1'b0, CLASS_SECOND};
    localparam logic [1:0] CLS_BAD_LO = 2'd2;
    localparam logic [1:0] CLS_BAD_HI = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    int        fail_count;
    int        results_due;
    int        cycle_count = 0;

    two_class_age_ordered_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    tcaof_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_results_due(results_due)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item op(input logic [1:0] kind, input logic [1:0] cls,
                                    input logic [TAG_W-1:0] tag);
        t_in_item it;
        it.kind       = kind;
        it.item_class = cls;
        it.item_tag   = tag;
        return it;
    endfunction

    // Mostly valid enqueues and dequeues; a few items carry arbitrary kind and class.
    function automatic t_in_item random_op(input int enq_pct);
        t_in_item it;
        it.item_tag = TAG_W'($urandom);
        if ($urandom_range(99) < 8) begin
            it.kind       = 2'($urandom);
            it.item_class = 2'($urandom);
        end else if ($urandom_range(99) < enq_pct) begin
            it.kind       = KIND_ENQ;
            it.item_class = {1'b0, 1'($urandom)};
        end else begin
            it.kind       = $urandom_range(1) ? KIND_DEQ_ANY : KIND_DEQ_NAMED;
            it.item_class = {1'b0, 1'($urandom)};
        end
        return it;
    endfunction

    // Holds the item on the channel until a transfer takes place.
    task automatic offer(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    initial begin : stimulus
        int burst_left;
        int seg_left;
        int enq_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(op(KIND_ENQ, CLS_FIRST, 16'h0000));
        offer(op(KIND_ENQ, CLS_SECOND, 16'hFFFF));
        offer(op(KIND_ENQ, CLS_FIRST, 16'hA5A5));
        offer(op(KIND_DEQ_ANY, CLS_FIRST, 16'h0000));
        offer(op(KIND_DEQ_ANY, CLS_SECOND, 16'h0000));
        // Only the first class holds an item now.
        offer(op(KIND_DEQ_ANY, CLS_FIRST, 16'h0000));
        offer(op(KIND_DEQ_ANY, CLS_FIRST, 16'hFFFF));
        offer(op(KIND_DEQ_NAMED, CLS_FIRST, 16'h0000));
        offer(op(KIND_ENQ, CLS_BAD_LO, 16'h5A5A));
        offer(op(KIND_DEQ_NAMED, CLS_BAD_HI, 16'h0000));
        offer(op(KIND_NONE, CLS_BAD_HI, 16'hFFFF));
        // Fill the second class, then overflow it by one.
        for (int i = 0; i <= QUEUE_DEPTH; i++) begin
            offer(op(KIND_ENQ, CLS_SECOND, TAG_W'(i * 16'h1111)));
        end
        offer(op(KIND_DEQ_NAMED, CLS_SECOND, 16'h0000));

        burst_left = $urandom_range(1, 16);
        seg_left   = 0;
        enq_pct    = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Segments lean toward filling or draining so both limits are reached.
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                case ($urandom_range(2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            end
            offer(random_op(enq_pct));
            seg_left--;
            burst_left--;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // The receiver runs its own pattern; once it holds off long enough for the
    // block to back up and stall its input.
    initial begin : receiver
        int  mode;
        int  span;
        int  rx_cycles;
        bit  hold_done;
        rx_cycles = 0;
        hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(20, 200);
            if (!hold_done && rx_cycles >= HOLD_START) begin
                mode      = 4;
                span      = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            repeat (span) begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= ($urandom_range(9) == 0);
                    3:       out_ready <= ($urandom_range(9) != 0);
                    default: out_ready <= 1'b0;
                endcase
                @(posedge clk);
                rx_cycles++;
            end
        end
    end

endmodule

// File: sim.f
+incdir+sv
sv/tcaof_pkg.sv
sv/two_class_age_ordered_fifo.sv
bench/tcaof_checker.sv
bench/two_class_age_ordered_fifo_tb.sv
